// ===== rtl/mhpq_pkg.sv =====
// Shared types, codes and sizes for the max-heap priority queue.
// Used by mhpq_cell and max_heap_priority_queue; depends on nothing else.
package mhpq_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned ValueW          = 32;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdDelete = 2'd1;
  localparam logic [1:0] CmdSort   = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] value_out;
    logic                     last;
  } out_item_t;

  // One storage slot of the chain
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
  } slot_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_UP,
    CELL_ROTATE
  } cell_op_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e                 op;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/max_heap_priority_queue.sv =====
// Priority queue top level: a chain of CAPACITY cells kept in descending order.
// Insert and delete update the cells and load the result into the output register
// together, and a new transaction is taken while idle whenever that register frees.
// Sorted readout rotates the whole ring once, pausing while the output is stalled,
// with input held off meanwhile.
// Reset clears all valid bits, the entry count and the output register.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::DefaultCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mhpq_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mhpq_pkg::out_item_t  out_item_o
);
  import mhpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned RotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic {ST_IDLE, ST_SORT} state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] emit_q, emit_d;
  logic [RotW-1:0] rot_q, rot_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  cell_ctrl_t      ctrl;
  slot_t           slots [CAPACITY];
  logic [CAPACITY-1:0] gts;
  logic [CAPACITY-1:0] valid_vec;

  logic out_free, in_take, tail_valid;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_take    = in_valid_i && in_ready_o;
  assign tail_valid = slots[CAPACITY-1].valid;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned Prev = (i == 0) ? CAPACITY - 1 : i - 1;
    slot_t prev_slot, next_slot;
    logic  prev_gt;

    assign prev_slot = slots[Prev];
    assign prev_gt   = (i == 0) ? 1'b0 : gts[Prev];
    if (i == CAPACITY - 1) begin : g_tail
      assign next_slot = '{valid: 1'b0, value: '0};
    end else begin : g_body
      assign next_slot = slots[i+1];
    end

    mhpq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .prev_i   (prev_slot),
      .next_i   (next_slot),
      .prev_gt_i(prev_gt),
      .slot_o   (slots[i]),
      .gt_o     (gts[i])
    );
    assign valid_vec[i] = slots[i].valid;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    emit_d      = emit_q;
    rot_d       = rot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl.op     = CELL_HOLD;
    ctrl.value  = in_item_i.value;

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          case (in_item_i.command)
            CmdInsert: begin
              out_valid_d = 1'b1;
              out_d       = '{status: StatusOk, value_out: '0, last: 1'b1};
              if (count_q == CntW'(CAPACITY)) begin
                out_d.status = StatusFull;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
            CmdDelete: begin
              out_valid_d = 1'b1;
              if (count_q == '0) begin
                out_d = '{status: StatusEmpty, value_out: '0, last: 1'b1};
              end else begin
                out_d   = '{status: StatusOk, value_out: slots[0].value, last: 1'b1};
                ctrl.op = CELL_SHIFT_UP;
                count_d = count_q - CntW'(1);
              end
            end
            CmdSort: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_d       = '{status: StatusEmpty, value_out: '0, last: 1'b1};
              end else begin
                state_d = ST_SORT;
                emit_d  = '0;
                rot_d   = '0;
              end
            end
            default: ;  // unused code: drop the transaction
          endcase
        end
      end
      ST_SORT: begin
        // Advance the ring unless a valid tail waits on a stalled output; the tail walks from the smallest entry upward
        if (!tail_valid || out_free) begin
          ctrl.op = CELL_ROTATE;
          if (tail_valid) begin
            out_valid_d = 1'b1;
            out_d       = '{status: StatusOk, value_out: slots[CAPACITY-1].value,
                            last: (emit_q + CntW'(1)) == count_q};
            emit_d      = emit_q + CntW'(1);
          end
          rot_d = rot_q + RotW'(1);
          if (rot_q == RotW'(CAPACITY - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      emit_q      <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      emit_q      <= emit_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Stored entries sit in a contiguous block at the head while not rotating
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> ((valid_vec & (valid_vec + CAPACITY'(1))) == '0))
    else $error("valid slots not contiguous from the head");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(valid_vec) == int'(count_q))
    else $error("entry count disagrees with valid slots");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_sort_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SORT |=> count_q == $past(count_q))
    else $error("readout changed the entry count");

endmodule

// ===== rtl/mhpq_cell.sv =====
// One slot of the sorted chain: holds a value and a valid bit, compares the
// broadcast value and exchanges data with its neighbors. Uses mhpq_pkg.
module mhpq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhpq_pkg::cell_ctrl_t ctrl_i,
  input  mhpq_pkg::slot_t     prev_i,
  input  mhpq_pkg::slot_t     next_i,
  input  logic                prev_gt_i,
  output mhpq_pkg::slot_t     slot_o,
  output logic                gt_o
);
  import mhpq_pkg::*;

  slot_t slot_q, slot_d;

  // An empty slot ranks below every value
  assign gt_o   = !slot_q.valid || ($signed(ctrl_i.value) > $signed(slot_q.value));
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (gt_o) begin
          if (prev_gt_i) begin
            slot_d = prev_i;
          end else begin
            slot_d.valid = 1'b1;
            slot_d.value = ctrl_i.value;
          end
        end
      end
      CELL_SHIFT_UP: slot_d = next_i;
      CELL_ROTATE:   slot_d = prev_i;
      default:       slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== dv/tb_max_heap_priority_queue.sv =====
// Testbench for max_heap_priority_queue: directed and random insert, delete-root
// and sorted-readout traffic, checked against a sorted mirror of the contents.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL only.
module tb_max_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int unsigned CAPACITY   = DefaultCapacity;
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int          StallLimit = 2000;
  localparam int signed   IntMax     = 32'sh7fff_ffff;
  localparam int signed   IntMin     = -32'sh7fff_ffff - 1;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Sorted ascending copy of what the queue holds
  int signed mirror_sorted[$];
  out_item_t outputs_due[$];

  bit idle_on = 1'b1;
  int err_count;
  int commands_sent;
  int results_checked;
  int sorts_sent;
  int full_rejects;
  int peak_fill;
  int stall_cycles;

  max_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic out_item_t make_output(logic [1:0] status, int signed value,
                                            logic last);
    out_item_t res;
    res.status    = status;
    res.value_out = value;
    res.last      = last;
    return res;
  endfunction

  // Update the mirror for one accepted transaction and queue the outputs it causes
  function automatic void mirror_apply(in_item_t item);
    int pos;
    case (item.command)
      CmdInsert: begin
        if (mirror_sorted.size() >= CAPACITY) begin
          outputs_due.push_back(make_output(StatusFull, 0, 1'b1));
          full_rejects++;
        end else begin
          pos = 0;
          while (pos < mirror_sorted.size() && mirror_sorted[pos] <= item.value) pos++;
          mirror_sorted.insert(pos, item.value);
          outputs_due.push_back(make_output(StatusOk, 0, 1'b1));
          if (mirror_sorted.size() > peak_fill) peak_fill = mirror_sorted.size();
        end
      end
      CmdDelete: begin
        if (mirror_sorted.size() == 0) begin
          outputs_due.push_back(make_output(StatusEmpty, 0, 1'b1));
        end else begin
          outputs_due.push_back(make_output(StatusOk, mirror_sorted.pop_back(), 1'b1));
        end
      end
      CmdSort: begin
        sorts_sent++;
        if (mirror_sorted.size() == 0) begin
          outputs_due.push_back(make_output(StatusEmpty, 0, 1'b1));
        end else begin
          foreach (mirror_sorted[i]) begin
            outputs_due.push_back(make_output(StatusOk, mirror_sorted[i],
                                              i == mirror_sorted.size() - 1));
          end
        end
      end
      default: begin
        // unused code: dropped by the block, nothing comes back
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_command(logic [1:0] cmd, int signed value);
    in_item_t item;
    item.command = cmd;
    item.value   = value;
    if (idle_on && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    mirror_apply(item);
    if (cmd != CmdUnused) commands_sent++;
  endtask

  function automatic int signed pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return $signed($urandom_range(6)) - 3;
    if (r < 30) begin
      case ($urandom_range(3))
        0: return IntMax;
        1: return IntMin;
        2: return IntMax - 1;
        default: return IntMin + 1;
      endcase
    end
    return $signed($urandom());
  endfunction

  task automatic test_empty_queue();
    send_command(CmdDelete, 0);
    send_command(CmdSort, 0);
    send_command(CmdUnused, 32'sh1234_5678);
  endtask

  task automatic test_extreme_values();
    send_command(CmdInsert, IntMax);
    send_command(CmdInsert, IntMin);
    send_command(CmdInsert, 0);
    send_command(CmdInsert, -1);
    send_command(CmdInsert, 1);
    send_command(CmdInsert, IntMax);
    send_command(CmdSort, -1);
    send_command(CmdDelete, IntMin);
    send_command(CmdDelete, 0);
    send_command(CmdUnused, -1);
    send_command(CmdDelete, 0);
    send_command(CmdSort, 0);
    repeat (3) send_command(CmdDelete, 0);
    send_command(CmdDelete, 0);
  endtask

  // Fill to capacity, hit the full case, read out the largest sort, drain
  task automatic test_fill_and_drain();
    repeat (CAPACITY) send_command(CmdInsert, pick_value());
    send_command(CmdInsert, IntMax);
    send_command(CmdInsert, IntMin);
    send_command(CmdSort, 0);
    repeat (CAPACITY) send_command(CmdDelete, $signed($urandom()));
    send_command(CmdDelete, 0);
  endtask

  task automatic test_random_traffic(int count, bit with_idle);
    int sent;
    int unsigned r;
    int unsigned insert_pct;
    idle_on = with_idle;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      insert_pct = (mirror_sorted.size() > 48) ? 35 : 62;
      if (r < 4) begin
        send_command(CmdUnused, $signed($urandom()));
      end else begin
        if (r < 8) send_command(CmdSort, $signed($urandom()));
        else if (r < 8 + insert_pct) send_command(CmdInsert, pick_value());
        else send_command(CmdDelete, $signed($urandom()));
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  // Check every output transaction and, while idle_on is set, randomly stall the output side
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (outputs_due.size() == 0) begin
        $error("unexpected output: status %0d value_out %0d last %0b",
               out_item_o.status, out_item_o.value_out, out_item_o.last);
        err_count++;
      end else begin
        want = outputs_due.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
          err_count++;
        end
        if (out_item_o.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_item_o.value_out);
          err_count++;
        end
        if (out_item_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_item_o.last);
          err_count++;
        end
      end
    end
    out_ready_i <= !(idle_on && $urandom_range(99) < 9);
  end

  // End the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extreme_values();
    test_fill_and_drain();
    test_random_traffic(60, 1'b0);
    test_random_traffic(110, 1'b1);
    in_valid_i <= 1'b0;

    while (outputs_due.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 16) @(posedge clk_i);
    if (outputs_due.size() != 0) begin
      $error("%0d expected outputs never arrived", outputs_due.size());
      err_count++;
    end

    $display("Sent %0d commands: %0d sorted readouts, %0d full rejections, peak fill %0d/%0d",
             commands_sent, sorts_sent, full_rejects, peak_fill, CAPACITY);
    $display("Checked %0d output transactions", results_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
